[rtl/cau_pkg.sv]
package cau_pkg;

  // Operand width; the divider chain has one cell per quotient bit.
  localparam int unsigned CauW = 8;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIVZERO  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Payload that travels down the cell chain.
  typedef struct packed {
    logic            is_div;  // quotient must be finished at the end of the chain
    logic            sgn;     // signed operation
    logic            neg;     // quotient is to be negated
    logic [CauW-1:0] den;     // divisor magnitude
    logic [CauW-1:0] rem;     // partial remainder
    logic [CauW-1:0] num;     // dividend bits still to consume, quotient bits shifted in
    logic [CauW:0]   value;   // finished result of the non-divide operations
    logic [1:0]      status;
  } cau_work_t;

endpackage

[rtl/cau_front.sv]
module cau_front
  import cau_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      kind,
  input  logic [CauW-1:0] operand_a,
  input  logic [CauW-1:0] operand_b,
  output logic            out_valid,
  input  logic            out_ready,
  output cau_work_t       out_data
);

  logic      valid_r;
  logic      valid_nxt;
  cau_work_t data_r;
  cau_work_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    logic               sgn;
    logic [1:0]         op;
    logic signed [8:0]  a9;
    logic signed [8:0]  b9;
    logic signed [9:0]  sum;
    logic signed [9:0]  dif;
    logic signed [17:0] prod;
    logic signed [17:0] res;
    logic signed [17:0] lo;
    logic signed [17:0] hi;
    sgn  = !kind[2];
    op   = kind[1:0];
    a9   = {sgn & operand_a[CauW-1], operand_a};
    b9   = {sgn & operand_b[CauW-1], operand_b};
    sum  = {a9[8], a9} + {b9[8], b9};
    dif  = {a9[8], a9} - {b9[8], b9};
    prod = a9 * b9;
    lo   = sgn ? -18'sd128 : 18'sd0;
    hi   = sgn ? 18'sd127 : 18'sd255;
    case (op)
      OP_ADD:  res = {{8{sum[9]}}, sum};
      OP_SUB:  res = {{8{dif[9]}}, dif};
      OP_MUL:  res = prod;
      default: res = '0;
    endcase

    data_nxt.is_div = (op == OP_DIV);
    data_nxt.sgn    = sgn;
    data_nxt.neg    = sgn && (operand_a[CauW-1] ^ operand_b[CauW-1]);
    data_nxt.den    = (sgn && operand_b[CauW-1]) ? CauW'(-operand_b) : operand_b;
    data_nxt.num    = (sgn && operand_a[CauW-1]) ? CauW'(-operand_a) : operand_a;
    data_nxt.rem    = '0;
    data_nxt.value  = '0;
    data_nxt.status = ST_OK;
    if (op == OP_DIV) begin
      if (operand_b == '0) begin
        data_nxt.status = ST_DIVZERO;
      end
    end else if (res < lo || res > hi) begin
      data_nxt.status = ST_OVERFLOW;
    end else begin
      data_nxt.value = res[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

[rtl/cau_div_cell.sv]
module cau_div_cell
  import cau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cau_work_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output cau_work_t out_data
);

  logic      valid_r;
  cau_work_t data_r;
  cau_work_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // One restoring step: bring down the next dividend bit and try the subtract.
  always_comb begin
    logic [CauW:0] trial;
    logic          qbit;
    trial    = {in_data.rem, in_data.num[CauW-1]};
    qbit     = (trial >= {1'b0, in_data.den});
    data_nxt = in_data;
    data_nxt.rem = qbit ? CauW'(trial - {1'b0, in_data.den}) : trial[CauW-1:0];
    data_nxt.num = {in_data.num[CauW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

[rtl/checked_8bit_arithmetic_unit_top.sv]
// Channel  Ports                        Contents
// input    in_tvalid/in_tready          in_tuser: kind; in_tdata: operand_a, operand_b
// output   out_tvalid/out_tready        out_tdata: value; out_tuser: status
//
// One transaction enters per cycle while the output is not stalled; each result
// passes through the front stage, the eight divider cells and the output register.
// Every stage advances when the next one is empty or advancing, so bubbles close up.
// A stall on the output backs up stage by stage to in_tready.
// Reset (rst_n low at a clock edge) empties every stage.
module checked_8bit_arithmetic_unit_top
  import cau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] operand_a, [15:8] operand_b
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [8:0] value, [15:9] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic      cv [CauW+1];
  logic      cr [CauW+1];
  cau_work_t cd [CauW+1];

  logic       out_valid_r;
  logic [8:0] value_r;
  logic [8:0] value_nxt;
  logic [1:0] status_r;
  logic [1:0] status_nxt;

  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .kind      (in_tuser),
    .operand_a (in_tdata[7:0]),
    .operand_b (in_tdata[15:8]),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_data  (cd[0])
  );

  for (genvar i = 0; i < CauW; i++) begin : g_cell
    cau_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_data   (cd[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_data  (cd[i+1])
    );
  end

  assign cr[CauW] = !out_valid_r || out_tready;

  // Finish the quotient: apply the sign and catch -128 / -1.
  always_comb begin
    cau_work_t w;
    w          = cd[CauW];
    value_nxt  = w.value;
    status_nxt = w.status;
    if (w.is_div && w.status == ST_OK) begin
      if (w.neg) begin
        value_nxt = 9'(-{1'b0, w.num});
      end else if (w.sgn && w.num[CauW-1]) begin
        value_nxt  = '0;
        status_nxt = ST_OVERFLOW;
      end else begin
        value_nxt = {1'b0, w.num};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cr[CauW]) begin
      out_valid_r <= cv[CauW];
    end
  end

  always_ff @(posedge clk) begin
    if (cr[CauW] && cv[CauW]) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, value_r};
  assign out_tuser  = status_r;

endmodule

[verif/checked_8bit_arithmetic_unit_top_tb.sv]
module checked_8bit_arithmetic_unit_top_tb;
  import cau_pkg::*;

  // Operation kinds: bit 2 picks unsigned operands, bits 1:0 pick the op.
  localparam logic [2:0] SADD = {1'b0, OP_ADD};
  localparam logic [2:0] SSUB = {1'b0, OP_SUB};
  localparam logic [2:0] SMUL = {1'b0, OP_MUL};
  localparam logic [2:0] SDIV = {1'b0, OP_DIV};
  localparam logic [2:0] UADD = {1'b1, OP_ADD};
  localparam logic [2:0] USUB = {1'b1, OP_SUB};
  localparam logic [2:0] UMUL = {1'b1, OP_MUL};
  localparam logic [2:0] UDIV = {1'b1, OP_DIV};

  localparam int RandomOps   = 550;
  localparam int SettleCycles = 20;

  typedef struct packed {
    logic [8:0] value;
    logic [1:0] status;
  } alu_result_t;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  a;
    logic [7:0]  b;
    bit          typed;
    alu_result_t want;
  } op_case_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  alu_result_t pending_results[$];
  int          mismatches;
  bit          sender_burst;
  bit          receiver_burst;

  // Rows with typed == 0 take their expectation from the predictor.
  op_case_t directed_cases [24] = '{
    '{SADD, 8'h7F, 8'h01, 1'b1, '{9'h000, ST_OVERFLOW}},
    '{SADD, 8'h80, 8'hFF, 1'b1, '{9'h000, ST_OVERFLOW}},
    '{SADD, 8'h7F, 8'h80, 1'b1, '{9'h1FF, ST_OK}},
    '{SSUB, 8'h80, 8'h01, 1'b1, '{9'h000, ST_OVERFLOW}},
    '{SSUB, 8'h00, 8'h80, 1'b1, '{9'h000, ST_OVERFLOW}},
    '{SSUB, 8'hFF, 8'h7F, 1'b1, '{9'h180, ST_OK}},
    '{SMUL, 8'h80, 8'hFF, 1'b1, '{9'h000, ST_OVERFLOW}},
    '{SMUL, 8'h80, 8'h01, 1'b1, '{9'h180, ST_OK}},
    '{SMUL, 8'h7F, 8'h7F, 1'b1, '{9'h000, ST_OVERFLOW}},
    '{SMUL, 8'hF5, 8'h0B, 1'b0, '{9'h000, ST_OK}},
    '{SDIV, 8'h80, 8'hFF, 1'b1, '{9'h000, ST_OVERFLOW}},
    '{SDIV, 8'h07, 8'h00, 1'b1, '{9'h000, ST_DIVZERO}},
    '{SDIV, 8'hF9, 8'h02, 1'b0, '{9'h000, ST_OK}},
    '{SDIV, 8'h7F, 8'h80, 1'b0, '{9'h000, ST_OK}},
    '{SDIV, 8'h80, 8'h80, 1'b0, '{9'h000, ST_OK}},
    '{UADD, 8'hFF, 8'h01, 1'b1, '{9'h000, ST_OVERFLOW}},
    '{UADD, 8'hFF, 8'h00, 1'b1, '{9'h0FF, ST_OK}},
    '{USUB, 8'h03, 8'h04, 1'b1, '{9'h000, ST_OVERFLOW}},
    '{USUB, 8'hFF, 8'hFF, 1'b1, '{9'h000, ST_OK}},
    '{UMUL, 8'hFF, 8'h00, 1'b1, '{9'h000, ST_OK}},
    '{UMUL, 8'hFF, 8'hFF, 1'b1, '{9'h000, ST_OVERFLOW}},
    '{UMUL, 8'h0F, 8'h11, 1'b1, '{9'h0FF, ST_OK}},
    '{UDIV, 8'hFF, 8'h00, 1'b1, '{9'h000, ST_DIVZERO}},
    '{UDIV, 8'hFF, 8'h01, 1'b1, '{9'h0FF, ST_OK}}
  };

  checked_8bit_arithmetic_unit_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("checked_8bit_arithmetic_unit_top verification failed");
    $finish;
  end

  function automatic alu_result_t predict_alu(logic [2:0] kind, logic [7:0] a, logic [7:0] b);
    int          sa;
    int          sb;
    int          res;
    int          lo;
    int          hi;
    alu_result_t r;
    res = 0;
    r.status = ST_OK;
    if (kind[2]) begin
      sa = int'(a);
      sb = int'(b);
      lo = 0;
      hi = 255;
    end else begin
      sa = int'($signed(a));
      sb = int'($signed(b));
      lo = -128;
      hi = 127;
    end
    case (kind[1:0])
      OP_ADD: res = sa + sb;
      OP_SUB: res = sa - sb;
      OP_MUL: res = sa * sb;
      default: begin
        // Integer division here truncates toward zero, as the block must.
        if (sb == 0) r.status = ST_DIVZERO;
        else res = sa / sb;
      end
    endcase
    if (r.status == ST_OK && (res < lo || res > hi)) r.status = ST_OVERFLOW;
    if (r.status != ST_OK) res = 0;
    r.value = res[8:0];
    return r;
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] corners [7] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF, 8'hFE, 8'h81};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 6)];
    return 8'($urandom);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_operation(logic [2:0] kind, logic [7:0] a, logic [7:0] b,
                                bit typed, alu_result_t want);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(typed ? want : predict_alu(kind, a, b));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // Result checker.
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h status=%0d",
                                  out_tdata[8:0], out_tuser));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[8:0] !== exp_r.value)
          report_mismatch($sformatf("value %h, expected %h", out_tdata[8:0], exp_r.value));
        if (out_tdata[15:9] !== 7'd0)
          report_mismatch($sformatf("padding bits %h not zero", out_tdata[15:9]));
        if (out_tuser !== exp_r.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_tuser, exp_r.status));
      end
    end
  end

  // Result receiver with random stalls.
  initial begin
    int gap;
    int taken;
    out_tready = 1'b0;
    receiver_burst = 1'b0;
    taken = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
      gap = receiver_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    alu_result_t none;
    none = '0;
    mismatches = 0;
    sender_burst = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_cases[i])
      send_operation(directed_cases[i].kind, directed_cases[i].a, directed_cases[i].b,
                     directed_cases[i].typed, directed_cases[i].want);
    drain_results();

    for (int i = 0; i < RandomOps; i++) begin
      if (i % 50 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      // Let the pipeline run completely empty once in the middle.
      if (i == RandomOps / 2) drain_results();
      send_operation(3'($urandom), pick_operand(), pick_operand(), 1'b0, none);
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk);
    if (mismatches == 0) begin
      $display("checked_8bit_arithmetic_unit_top verification clean");
    end else begin
      $display("checked_8bit_arithmetic_unit_top verification failed");
    end
    $finish;
  end

endmodule
